/* sv/pal_pkg.sv */
// shared constants, codes and types of the positional array list
package pal_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FPOS_W   = 7;
  localparam int unsigned COUNT_W  = 7;

  // wide enough for position and count arithmetic without wrap
  localparam int unsigned CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_DELETE = 3'd1,
    KIND_READ   = 3'd2,
    KIND_LOCATE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  eval;
    logic  ins;
    logic  del;
    idx_t  sel;
    cnt_t  count;
    data_t key;
  } cell_ctrl_t;

endpackage

/* sv/pal_if.sv */
// request and response channels of the positional array list
interface pal_req_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value_in;

  modport source (output valid, kind, position, value_in, input ready);
  modport sink   (input valid, kind, position, value_in, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] value_out;
  logic [FPOS_W-1:0]        found_position;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, status, value_out, found_position, count, input ready);
  modport sink   (input valid, status, value_out, found_position, count, output ready);
endinterface

/* sv/positional_array_list.sv */
// top level of the positional array list: sequencer, cell chain and result register
//
// An ordered list of up to CAPACITY (64) signed 32-bit values held in a chain of
// cells, one entry per cell. Each request beat is one operation: insert before a
// 1-based position (position count+1 appends), delete at a position (returns the
// removed value), read at a position, locate the first position holding a value,
// or clear. Every request gives exactly one response beat with status, value,
// found position and the count held afterwards. In each operation the beat is
// registered, then every cell compares its own index and entry in parallel and
// registers the outcome, then the merged taps and the lowest match form the
// response while the cells at and above the position shift one place up or down
// at once. The request side is ready again once the response is in the output
// register, so a new request is taken only after the last operation is done; a
// response that is not taken holds the commit step and with it the next request.
// Entries beyond the count are never read, so the list needs no clearing after
// reset and accepts requests from the first cycle.
module positional_array_list import pal_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  pal_req_if.sink         req_i,
  pal_rsp_if.source       rsp_o
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_q, state_d;

  // latched request
  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_q;
  data_t             key_q;

  cnt_t count_q, count_d;

  // response register
  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] status_q;
  data_t               value_q;
  logic [FPOS_W-1:0]   fpos_q;

  logic req_fire;
  logic commit_fire;

  // decoded commit outcome
  status_e             status_d;
  data_t               value_d;
  logic [FPOS_W-1:0]   fpos_d;
  logic                ins_go;
  logic                del_go;

  cmp_t pos_w;
  cmp_t cnt_w;
  idx_t sel_idx;

  cell_ctrl_t ctrl;

  // cell chain wiring
  data_t               entry_w [CAPACITY];
  data_t               tap_w   [CAPACITY];
  logic [CAPACITY-1:0] match_w;

  data_t               red_value;
  logic                red_found;
  idx_t                red_index;
  logic [CAPACITY-1:0] red_first;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign commit_fire = (state_q == ST_COMMIT) && (!rsp_valid_q || rsp_o.ready);

  assign pos_w   = cmp_t'(pos_q);
  assign cnt_w   = cmp_t'(count_q);
  // only meaningful when the position is in range
  assign sel_idx = idx_t'(pos_w - cmp_t'(1));

  // status and list update for the latched operation
  always_comb begin
    status_d = ST_OK;
    value_d  = '0;
    fpos_d   = '0;
    ins_go   = 1'b0;
    del_go   = 1'b0;
    count_d  = count_q;
    unique case (kind_e'(kind_q))
      KIND_INSERT: begin
        if (cnt_w >= cmp_t'(CAPACITY)) begin
          status_d = ST_FULL;
        end else if (pos_w == '0 || pos_w > cnt_w + cmp_t'(1)) begin
          status_d = ST_BADPOS;
        end else begin
          ins_go  = 1'b1;
          count_d = count_q + cnt_t'(1);
        end
      end
      KIND_DELETE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          status_d = ST_BADPOS;
        end else begin
          value_d = red_value;
          del_go  = 1'b1;
          count_d = count_q - cnt_t'(1);
        end
      end
      KIND_READ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          status_d = ST_BADPOS;
        end else begin
          value_d = red_value;
        end
      end
      KIND_LOCATE: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else if (red_found) begin
          fpos_d = FPOS_W'(cmp_t'(red_index) + cmp_t'(1));
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        // unused codes leave everything as is
      end
    endcase
  end

  // broadcast to the cells; shifts only when the response is written
  assign ctrl = '{
    eval:  (state_q == ST_EVAL),
    ins:   commit_fire && ins_go,
    del:   commit_fire && del_go,
    sel:   sel_idx,
    count: count_q,
    key:   key_q
  };

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t below;
    data_t above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = entry_w[g+1];
    end

    pal_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (idx_t'(g)),
      .ctrl_i  (ctrl),
      .below_i (below),
      .above_i (above),
      .entry_o (entry_w[g]),
      .tap_o   (tap_w[g]),
      .match_o (match_w[g])
    );
  end

  pal_reduce u_reduce (
    .tap_i   (tap_w),
    .match_i (match_w),
    .value_o (red_value),
    .found_o (red_found),
    .index_o (red_index),
    .first_o (red_first)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_fire) state_d = ST_EVAL;
      ST_EVAL:   state_d = ST_COMMIT;
      ST_COMMIT: if (commit_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (commit_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (commit_fire) begin
        count_q <= count_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      kind_q <= req_i.kind;
      pos_q  <= req_i.position;
      key_q  <= req_i.value_in;
    end
    if (commit_fire) begin
      status_q <= status_d;
      value_q  <= value_d;
      fpos_q   <= fpos_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.value_out      = value_q;
  assign rsp_o.found_position = fpos_q;
  assign rsp_o.count          = COUNT_W'(count_q);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_w <= cmp_t'(CAPACITY))
    else $error("entry count above capacity");

  a_rsp_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("response appeared without a commit step");

  // match flags are only settled once an evaluate step has run
  a_first_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> $onehot0(red_first))
    else $error("more than one first match selected");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + cnt_t'(1))
    else $error("insert did not grow the list by one");

  a_no_shift_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.del) && !(ctrl.eval && (ctrl.ins || ctrl.del)))
    else $error("conflicting cell commands");
`endif

endmodule

/* sv/pal_cell.sv */
// one list cell: holds an entry, shifts with its neighbors, compares locally
module pal_cell import pal_pkg::*; (
  input  logic       clk_i,
  input  idx_t       idx_i,
  input  cell_ctrl_t ctrl_i,
  input  data_t      below_i,
  input  data_t      above_i,
  output data_t      entry_o,
  output data_t      tap_o,
  output logic       match_o
);

  data_t entry_q, entry_d;
  data_t tap_q;
  logic  match_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (idx_i > ctrl_i.sel) begin
        entry_d = below_i;
      end else if (idx_i == ctrl_i.sel) begin
        entry_d = ctrl_i.key;
      end
    end else if (ctrl_i.del) begin
      if (idx_i >= ctrl_i.sel) begin
        entry_d = above_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    if (ctrl_i.eval) begin
      tap_q   <= (idx_i == ctrl_i.sel) ? entry_q : '0;
      match_q <= (entry_q == ctrl_i.key) && (cnt_t'(idx_i) < ctrl_i.count);
    end
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;
  assign match_o = match_q;

endmodule

/* sv/pal_reduce.sv */
// merges the cell taps and picks the lowest matching cell
module pal_reduce import pal_pkg::*; (
  input  data_t               tap_i [CAPACITY],
  input  logic [CAPACITY-1:0] match_i,
  output data_t               value_o,
  output logic                found_o,
  output idx_t                index_o,
  output logic [CAPACITY-1:0] first_o
);

  logic [CAPACITY-1:0] first;

  // isolate the lowest set bit
  assign first = match_i & (~match_i + CAPACITY'(1));

  always_comb begin
    value_o = '0;
    index_o = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      value_o = value_o | tap_i[k];
      if (first[k]) begin
        index_o = index_o | idx_t'(k);
      end
    end
  end

  assign found_o = |match_i;
  assign first_o = first;

endmodule

/* bench/pal_checker.sv */
// response predictor and scoreboard for the positional array list
module pal_checker import pal_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  pal_req_if   req_i,
  pal_rsp_if   rsp_i,
  output int   errors_o,
  output int   pending_o,
  output int   occupancy_o,
  output int   checked_o,
  output int   full_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e             status;
    data_t               value;
    logic [FPOS_W-1:0]   fpos;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  data_t        list_mem [CAPACITY];
  int           list_len;
  list_result_t result_q [$];
  list_result_t want;

  // applies one operation to the shadow list and returns the response it gives
  function automatic list_result_t apply_op(input logic [KIND_W-1:0] kind,
                                            input logic [POS_W-1:0] pos,
                                            input data_t val);
    list_result_t res;
    int p;
    int k;
    res.status = ST_OK;
    res.value  = '0;
    res.fpos   = '0;
    res.count  = '0;
    p = int'(pos);
    case (kind)
      KIND_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (p < 1 || p > list_len + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      KIND_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.value = list_mem[p-1];
          for (k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      KIND_READ: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else if (p < 1 || p > list_len) begin
          res.status = ST_BADPOS;
        end else begin
          res.value = list_mem[p-1];
        end
      end
      KIND_LOCATE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_NOTFOUND;
          for (k = 0; k < list_len; k++) begin
            if (list_mem[k] == val) begin
              res.status = ST_OK;
              res.fpos   = FPOS_W'(k + 1);
              break;
            end
          end
        end
      end
      KIND_CLEAR: list_len = 0;
      default: ;
    endcase
    res.count = COUNT_W'(list_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      result_q.delete();
    end else begin
      // response first: it can never belong to a request taken on the same edge
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (result_q.size() == 0) begin
          $error("response beat with no operation outstanding");
          errors_o++;
        end else begin
          want = result_q.pop_front();
          checked_o++;
          if (rsp_i.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp_i.status);
            errors_o++;
          end
          if (rsp_i.value_out !== want.value) begin
            $error("value_out mismatch: expected %0d, actual %0d",
                   $signed(want.value), rsp_i.value_out);
            errors_o++;
          end
          if (rsp_i.found_position !== want.fpos) begin
            $error("found_position mismatch: expected %0d, actual %0d",
                   want.fpos, rsp_i.found_position);
            errors_o++;
          end
          if (rsp_i.count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, rsp_i.count);
            errors_o++;
          end
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        result_q.push_back(apply_op(req_i.kind, req_i.position, req_i.value_in));
        if (result_q[$].status == ST_FULL) full_hits_o++;
      end
    end
    pending_o   = result_q.size();
    occupancy_o = list_len;
  end

endmodule

/* bench/tb.sv */
// stimulus, clocking and verdict for the positional array list
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pal_pkg::*;

  localparam int unsigned CLK_PERIOD      = 10;
  localparam int unsigned RESET_CYCLES    = 6;
  localparam int unsigned RANDOM_OPS      = 525;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES    = 20;
  // ~550 ops, each allowing for its longest idle gap, response stall and operation, several times over
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // kind codes the block treats as no operation
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI  = 3'd7;

  // flavor of a run of random operations
  typedef enum int {EP_FILL, EP_GROW, EP_SHRINK, EP_MIXED, EP_NOISE} episode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pal_req_if req ();
  pal_rsp_if rsp ();

  int errors;
  int pending;
  int occupancy;
  int checked;
  int full_hits;

  int unsigned ops_sent;
  int unsigned directed_sent;
  int unsigned random_sent;
  int unsigned cycle_cnt;
  int unsigned longest_stall;
  bit          hold_off_req;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  positional_array_list uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  pal_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_i       (rsp),
    .errors_o    (errors),
    .pending_o   (pending),
    .occupancy_o (occupancy),
    .checked_o   (checked),
    .full_hits_o (full_hits)
  );

  // safety net against a hung handshake
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // idle cycles before a request beat: mostly none or a few, now and then a long gap
  function automatic int unsigned pick_gap(input bit burst);
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small values repeat often so locate finds hits and duplicates
  function automatic data_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return data_t'(int'($urandom_range(0, 15)) - 8);
    if (r < 60) return 32'h8000_0000;
    if (r < 65) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  // a position inside the list, or position 1 when it is empty
  function automatic logic [POS_W-1:0] held_pos(input int len);
    return POS_W'($urandom_range(1, (len == 0) ? 1 : len));
  endfunction

  // insert, delete or read for the off-the-end position checks
  function automatic logic [KIND_W-1:0] KIND_LOGIC_PICK(input int unsigned r);
    case (r % 3)
      0:       return KIND_INSERT;
      1:       return KIND_DELETE;
      default: return KIND_READ;
    endcase
  endfunction

  // one request beat; returns at the falling edge after it was taken
  task automatic issue_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input data_t val, input int unsigned gap);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.position <= pos;
    req.value_in <= val;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    @(negedge clk_i);
    ops_sent++;
  endtask

  // picks an operation shaped by the episode flavor and the current list length
  task automatic random_op(input episode_e mode, input bit burst);
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    data_t             val;
    int                len;
    int unsigned       r;
    len = occupancy;
    r   = $urandom_range(0, 99);
    val = pick_value();
    pos = held_pos(len);
    case (mode)
      EP_FILL: begin
        kind = KIND_INSERT;
        pos  = POS_W'($urandom_range(1, len + 1));
      end
      EP_GROW: begin
        if (r < 70) begin
          kind = KIND_INSERT;
          pos  = POS_W'($urandom_range(1, len + 1));
        end else if (r < 80) kind = KIND_READ;
        else if (r < 90) kind = KIND_LOCATE;
        else kind = KIND_DELETE;
      end
      EP_SHRINK: begin
        if (r < 65) kind = KIND_DELETE;
        else if (r < 80) kind = KIND_READ;
        else if (r < 90) begin
          kind = KIND_INSERT;
          pos  = POS_W'($urandom_range(1, len + 1));
        end else kind = KIND_LOCATE;
      end
      EP_MIXED: begin
        if (r < 25) begin
          kind = KIND_INSERT;
          pos  = POS_W'($urandom_range(1, len + 1));
        end else if (r < 45) kind = KIND_DELETE;
        else if (r < 65) kind = KIND_READ;
        else if (r < 85) kind = KIND_LOCATE;
        else if (r < 88) kind = KIND_CLEAR;
        else begin
          // the last position, the one just past the end of the list, or anywhere at all
          kind = KIND_LOGIC_PICK(r);
          case ($urandom_range(0, 2))
            0:       pos = POS_W'(len);
            1:       pos = POS_W'(len + 1);
            default: pos = POS_W'($urandom_range(0, 127));
          endcase
        end
      end
      default: begin
        kind = KIND_W'($urandom_range(0, KIND_UNUSED_HI));
        pos  = POS_W'($urandom_range(0, 127));
        val  = $urandom;
      end
    endcase
    issue_op(kind, pos, val, pick_gap(burst));
    random_sent++;
  endtask

  // response side: ready stretches, short and long stalls, and one long hold-off
  initial begin
    int unsigned n;
    bit          hold_done;
    rsp.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        rsp.ready <= 1'b0;
        n = HOLD_OFF_CYCLES;
      end else if ($urandom_range(0, 2) != 0) begin
        rsp.ready <= 1'b1;
        n = 0;
        repeat ($urandom_range(1, 25)) @(negedge clk_i);
      end else begin
        rsp.ready <= 1'b0;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (n > longest_stall) longest_stall = n;
      repeat (n) @(negedge clk_i);
    end
  end

  // request side
  initial begin
    episode_e    mode;
    int unsigned ep_len;
    bit          burst;
    int unsigned ep;
    req.valid    = 1'b0;
    req.kind     = KIND_INSERT;
    req.position = '0;
    req.value_in = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty list, bad positions, extremes, append, duplicates, no-op kinds
    issue_op(KIND_READ,   7'd1,   '0,            pick_gap(1'b0)); // read on empty
    issue_op(KIND_DELETE, 7'd1,   '0,            pick_gap(1'b0)); // delete on empty
    issue_op(KIND_LOCATE, 7'd0,   '0,            pick_gap(1'b0)); // locate on empty
    issue_op(KIND_INSERT, 7'd0,   32'd5,         pick_gap(1'b0)); // position zero
    issue_op(KIND_INSERT, 7'd2,   32'd5,         pick_gap(1'b0)); // past append slot
    issue_op(KIND_INSERT, 7'd1,   32'h8000_0000, pick_gap(1'b0)); // most negative
    issue_op(KIND_INSERT, 7'd2,   32'h7fff_ffff, pick_gap(1'b0)); // append, most positive
    issue_op(KIND_INSERT, 7'd1,   32'd0,         pick_gap(1'b0)); // insert at front
    issue_op(KIND_INSERT, 7'd127, 32'hffff_ffff, pick_gap(1'b0)); // all position bits set
    issue_op(KIND_READ,   7'd3,   '0,            pick_gap(1'b0)); // read last entry
    issue_op(KIND_READ,   7'd4,   '0,            pick_gap(1'b0)); // one past the end
    issue_op(KIND_READ,   7'd0,   '0,            pick_gap(1'b0));
    issue_op(KIND_LOCATE, 7'd0,   32'h8000_0000, pick_gap(1'b0));
    issue_op(KIND_LOCATE, 7'd0,   32'd12345,     pick_gap(1'b0)); // no match
    issue_op(KIND_INSERT, 7'd2,   32'd0,         pick_gap(1'b0)); // duplicate zero
    issue_op(KIND_LOCATE, 7'd0,   32'd0,         pick_gap(1'b0)); // first of two matches
    issue_op(KIND_DELETE, 7'd2,   '0,            pick_gap(1'b0)); // delete in the middle
    issue_op(KIND_DELETE, 7'd4,   '0,            pick_gap(1'b0)); // past the end
    issue_op(KIND_DELETE, 7'd3,   '0,            pick_gap(1'b0)); // delete last entry
    issue_op(KIND_UNUSED_LO,  7'd7,   32'h1234_5678, pick_gap(1'b0));
    issue_op(KIND_UNUSED_MID, 7'd1,   32'd0,         pick_gap(1'b0));
    issue_op(KIND_UNUSED_HI,  7'd127, 32'hffff_ffff, pick_gap(1'b0));
    issue_op(KIND_CLEAR,  7'd0,   '0,            pick_gap(1'b0));
    issue_op(KIND_CLEAR,  7'd0,   '0,            pick_gap(1'b0)); // clear on empty
    issue_op(KIND_READ,   7'd1,   '0,            pick_gap(1'b0)); // read after clear
    directed_sent = ops_sent;

    // random episodes; the first one fills the list past capacity
    ep = 0;
    while (random_sent < RANDOM_OPS) begin
      mode   = (ep == 0) ? EP_FILL : episode_e'($urandom_range(EP_GROW, EP_NOISE));
      ep_len = (mode == EP_FILL) ? 75 : $urandom_range(15, 60);
      if (ep_len > RANDOM_OPS - random_sent) ep_len = RANDOM_OPS - random_sent;
      burst  = ($urandom_range(0, 3) == 0);
      if (ep == 2) begin
        // keep offering back to back while the response side holds off
        hold_off_req = 1'b1;
        burst        = 1'b1;
      end
      repeat (ep_len) random_op(mode, burst);
      if (ep % 4 == 3) begin
        // let the block drain completely before going on
        req.valid <= 1'b0;
        @(negedge clk_i);
        while (pending != 0) @(negedge clk_i);
      end
      ep++;
    end

    req.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("run covered %0d operations (%0d directed, %0d random), %0d responses checked",
             ops_sent, directed_sent, random_sent, checked);
    $display("list found full %0d times, longest response stall %0d cycles",
             full_hits, longest_stall);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
